@@ hw/rtl/fvco_pkg.sv @@
// Package for the flow vector color overlay: widths, CORDIC angle table,
// register addresses and the stage data type. No dependencies.
`default_nettype none
package fvco_pkg;
  localparam int CordicStages = 14;
  localparam int HueBits = 12;
  localparam int AtanEntries = 24;
  localparam int CW = 20;  // CORDIC x/y width: 16 bits plus growth and sign
  localparam logic [31:0] KinvQ16 = 32'd39797;

  localparam logic [2:0] RegSaturation = 3'd0;
  localparam logic [2:0] RegLightness = 3'd1;
  localparam logic [2:0] RegAlphaGain = 3'd2;
  localparam logic [2:0] RegAlphaMax = 3'd3;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0] z;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } stage_t;

  function automatic logic [31:0] atan_turns(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'h20000000; 1: t = 32'h12E4051E; 2: t = 32'h09FB385B;
      3: t = 32'h051111D4; 4: t = 32'h028B0D43; 5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E; 7: t = 32'h00517C55; 8: t = 32'h0028BE53;
      9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
      default: t = 32'h0;
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

@@ hw/rtl/fvco_cell.sv @@
// One CORDIC vectoring cell: a micro-rotation by a fixed shift and angle,
// registered, moving with a valid bit. Depends on fvco_pkg.
`default_nettype none
module fvco_cell (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire logic [4:0] shift,
  input  wire logic [31:0] angle,
  input  wire logic in_valid,
  input  wire fvco_pkg::stage_t in_data,
  output logic out_valid,
  output fvco_pkg::stage_t out_data
);
  fvco_pkg::stage_t nxt;
  logic signed [fvco_pkg::CW-1:0] dx, dy;

  always_comb begin
    dx = in_data.y >>> shift;
    dy = in_data.x >>> shift;
    nxt = in_data;
    if (!in_data.y[fvco_pkg::CW-1]) begin
      nxt.x = in_data.x + dx;
      nxt.y = in_data.y - dy;
      nxt.z = in_data.z + angle;
    end else begin
      nxt.x = in_data.x - dx;
      nxt.y = in_data.y + dy;
      nxt.z = in_data.z - angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= nxt;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/fvco_color.sv @@
// Back end: hue rounding, magnitude and alpha, HSL channels and blend over
// four registered steps. Depends on fvco_pkg.
`default_nettype none
module fvco_color (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire logic in_valid,
  input  wire fvco_pkg::stage_t in_data,
  input  wire logic [7:0] sat,
  input  wire logic [7:0] lig,
  input  wire logic [15:0] gain,
  input  wire logic [8:0] amax,
  output logic out_valid,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);
  localparam int HB = fvco_pkg::HueBits;
  localparam int PW = HB + 3;
  localparam logic [PW-1:0] Unit = PW'(1) << HB;
  localparam logic [PW-1:0] Unit2 = PW'(2) << HB;
  localparam logic [PW-1:0] Unit4 = PW'(4) << HB;

  // step 1: hue, magnitude, HSL v1 and v2
  logic v1_valid;
  logic [HB-1:0] hue1;
  logic [16:0] mag1;
  logic [16:0] v1a, v2a;
  logic [23:0] orig1;
  logic [HB-1:0] hue_c;
  logic [31:0] zr;
  logic [47:0] mprod;
  logic [16:0] mag_c;
  logic [15:0] ls;
  logic [16:0] v2_c;

  always_comb begin
    zr = in_data.z + (32'd1 << (31 - HB));
    hue_c = zr[31 -: HB];
    mprod = 48'(in_data.x[fvco_pkg::CW-2:0]) * 48'(fvco_pkg::KinvQ16) + 48'd32768;
    mag_c = in_data.x[fvco_pkg::CW-1] ? 17'd0 : mprod[32:16];
    ls = lig * sat;
    if (!lig[7]) v2_c = {1'b0, lig, 8'd0} + 17'(ls);
    else v2_c = {1'b0, lig, 8'd0} + {1'b0, sat, 8'd0} - 17'(ls);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hue1 <= hue_c;
      mag1 <= mag_c;
      v2a <= v2_c;
      v1a <= {lig, 9'd0} - v2_c;
      orig1 <= {in_data.red, in_data.green, in_data.blue};
    end
  end

  // step 2: alpha and the three phases
  logic v2_valid;
  logic [8:0] alpha2;
  logic [PW-1:0] ph2 [3];
  logic [16:0] v1b, v2b;
  logic [23:0] orig2;
  logic [32:0] aprod;
  logic [8:0] alpha_c;
  logic [PW-1:0] base, ph_c [3];

  always_comb begin
    aprod = 33'(mag1) * 33'(gain);
    alpha_c = (amax > 9'd256) ? 9'd256 : amax;
    if (aprod < 33'(alpha_c)) alpha_c = aprod[8:0];
    base = PW'(hue1) * PW'(6);
    // The phase offsets wrap at six units; the wrap is chosen before adding.
    ph_c[0] = (base >= Unit4) ? base - Unit4 : base + Unit2;
    ph_c[1] = base;
    ph_c[2] = (base >= Unit2) ? base - Unit2 : base + Unit4;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      alpha2 <= alpha_c;
      ph2 <= ph_c;
      v1b <= v1a;
      v2b <= v2a;
      orig2 <= orig1;
    end
  end

  // step 3: channel values
  logic v3_valid;
  logic [16:0] ch3 [3];
  logic [8:0] alpha3;
  logic [23:0] orig3;
  logic [16:0] ch_c [3];
  logic signed [18:0] diff;
  logic signed [18+PW:0] prod;

  always_comb begin
    diff = 19'(v2b) - 19'(v1b);
    for (int k = 0; k < 3; k++) begin
      prod = '0;
      if (ph2[k] < Unit) begin
        prod = diff * $signed({1'b0, ph2[k]}) + (1 <<< (HB - 1));
        ch_c[k] = v1b + 17'(prod >>> HB);
      end else if (ph2[k] < 3 * Unit) begin
        ch_c[k] = v2b;
      end else if (ph2[k] < 4 * Unit) begin
        prod = diff * $signed({1'b0, PW'(4 * Unit - ph2[k])}) + (1 <<< (HB - 1));
        ch_c[k] = v1b + 17'(prod >>> HB);
      end else begin
        ch_c[k] = v1b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ch3 <= ch_c;
      alpha3 <= alpha2;
      orig3 <= orig2;
    end
  end

  // step 4: blend and saturate
  logic [7:0] bl_c [3];
  logic [43:0] num;
  logic [20:0] r;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num = 44'd255 * 44'(ch3[k]) * 44'(alpha3)
          + (44'(orig3[23 - 8*k -: 8]) * 44'(9'd256 - alpha3) << 16) + (44'd1 << 23);
      r = num[43:23] >> 1;
      bl_c[k] = (r > 21'd255) ? 8'd255 : r[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red <= bl_c[0];
      green <= bl_c[1];
      blue <= bl_c[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1_valid <= 1'b0;
      v2_valid <= 1'b0;
      v3_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1_valid <= in_valid;
      v2_valid <= v1_valid;
      v3_valid <= v2_valid;
      out_valid <= v3_valid;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/flow_vector_color_overlay.sv @@
// Flow vector color overlay: CORDIC cell chain, color back end, APB registers.
// Stages: CordicStages cells (14) plus 4 back-end steps; one pixel per cycle unless the output stalls.
// The whole pipeline advances together unless the output is stalled while valid_out is high.
// Synchronous active-high reset clears the valid bits and loads register defaults.
// Depends on fvco_pkg, fvco_cell, fvco_color.
`default_nettype none
module flow_vector_color_overlay (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [3:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  wire logic valid_in,
  output logic stall_in,
  input  wire logic signed [15:0] flow_x,
  input  wire logic signed [15:0] flow_y,
  input  wire logic [7:0] orig_red,
  input  wire logic [7:0] orig_green,
  input  wire logic [7:0] orig_blue,
  output logic valid_out,
  input  wire logic stall_out,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);
  localparam int N = fvco_pkg::CordicStages;
  logic [7:0] sat, lig;
  logic [15:0] gain;
  logic [8:0] amax;
  logic adv;

  assign pready = 1'b1;
  assign adv = !(valid_out && stall_out);
  assign stall_in = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      sat <= 8'd204;
      lig <= 8'd77;
      gain <= 16'd100;
      amax <= 9'd204;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        fvco_pkg::RegSaturation[1:0]: sat <= pwdata[7:0];
        fvco_pkg::RegLightness[1:0]: lig <= pwdata[7:0];
        fvco_pkg::RegAlphaGain[1:0]: gain <= pwdata[15:0];
        fvco_pkg::RegAlphaMax[1:0]: amax <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      fvco_pkg::RegSaturation[1:0]: prdata = {24'd0, sat};
      fvco_pkg::RegLightness[1:0]: prdata = {24'd0, lig};
      fvco_pkg::RegAlphaGain[1:0]: prdata = {16'd0, gain};
      fvco_pkg::RegAlphaMax[1:0]: prdata = {23'd0, amax};
      default: prdata = '0;
    endcase
  end

  // Prerotation: vectors with negative CORDIC x are negated and start at a half turn.
  fvco_pkg::stage_t head;
  always_comb begin
    head.x = fvco_pkg::CW'(flow_y);
    head.y = fvco_pkg::CW'(flow_x);
    head.z = '0;
    if (flow_y[15]) begin
      head.x = -head.x;
      head.y = -head.y;
      head.z = 32'h80000000;
    end
    head.red = orig_red;
    head.green = orig_green;
    head.blue = orig_blue;
  end

  fvco_pkg::stage_t sd [N+1];
  logic sv [N+1];
  assign sd[0] = head;
  assign sv[0] = valid_in;

  for (genvar i = 0; i < N; i++) begin : g_cell
    fvco_cell u_cell (
      .clk(clk), .rst(rst), .adv(adv),
      .shift(5'(i)), .angle(fvco_pkg::atan_turns(i)),
      .in_valid(sv[i]), .in_data(sd[i]),
      .out_valid(sv[i+1]), .out_data(sd[i+1])
    );
  end

  fvco_color u_color (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(sv[N]), .in_data(sd[N]),
    .sat(sat), .lig(lig), .gain(gain), .amax(amax),
    .out_valid(valid_out), .red(out_red), .green(out_green), .blue(out_blue)
  );
endmodule
`default_nettype wire
